>>> src/ubxa_pkg.sv
// ============================================================================
// ubxa_pkg
// Shared types, constants and the expected-byte function of the acknowledge
// frame checker.
// ============================================================================
package ubxa_pkg;

    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned BODY_BYTES  = FRAME_BYTES - 2;
    localparam int unsigned BODY_CNT_W  = $clog2(BODY_BYTES);

    localparam logic [7:0] SYNC_ONE  = 8'hB5;
    localparam logic [7:0] SYNC_TWO  = 8'h62;
    localparam logic [7:0] ACK_CLASS = 8'h05;
    localparam logic [7:0] ACK_ID    = 8'h01;
    localparam logic [7:0] LEN_LOW   = 8'h02;
    localparam logic [7:0] LEN_HIGH  = 8'h00;
    localparam logic [7:0] CK_A_BASE = 8'h08;
    localparam logic [7:0] CK_B_BASE = 8'd43;

    localparam logic [BODY_CNT_W-1:0] POS_ACK_CLASS = BODY_CNT_W'(0);
    localparam logic [BODY_CNT_W-1:0] POS_ACK_ID    = BODY_CNT_W'(1);
    localparam logic [BODY_CNT_W-1:0] POS_LEN_LOW   = BODY_CNT_W'(2);
    localparam logic [BODY_CNT_W-1:0] POS_LEN_HIGH  = BODY_CNT_W'(3);
    localparam logic [BODY_CNT_W-1:0] POS_CLASS     = BODY_CNT_W'(4);
    localparam logic [BODY_CNT_W-1:0] POS_ID        = BODY_CNT_W'(5);
    localparam logic [BODY_CNT_W-1:0] POS_CK_A      = BODY_CNT_W'(6);
    localparam logic [BODY_CNT_W-1:0] POS_CK_B      = BODY_CNT_W'(7);

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_CLASS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_ID    = 1'b1;

    typedef struct packed {
        logic [7:0] exp_class;
        logic [7:0] exp_id;
    } t_cfg;

    typedef struct packed {
        logic [7:0] seen_id;
        logic [7:0] seen_class;
        logic       ack_match;
    } t_result;

    // Expected value of a body byte; the count starts at the first byte after
    // the sync pair.
    function automatic logic [7:0] expected_byte(input logic [BODY_CNT_W-1:0] cnt,
                                                 input t_cfg cfg);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] val;
        ck_a = CK_A_BASE + cfg.exp_class + cfg.exp_id;
        ck_b = CK_B_BASE + {cfg.exp_class[6:0], 1'b0} + cfg.exp_id;
        case (cnt)
            POS_ACK_CLASS: val = ACK_CLASS;
            POS_ACK_ID:    val = ACK_ID;
            POS_LEN_LOW:   val = LEN_LOW;
            POS_LEN_HIGH:  val = LEN_HIGH;
            POS_CLASS:     val = cfg.exp_class;
            POS_ID:        val = cfg.exp_id;
            POS_CK_A:      val = ck_a;
            default:       val = ck_b;
        endcase
        return val;
    endfunction

endpackage

>>> src/ubx_ack_frame_checker.sv
// ============================================================================
// ubx_ack_frame_checker
// Finds acknowledge frames in a received byte stream and checks them.
// ============================================================================
// Each slave beat carries one received byte in s_axis_tdata[7:0]. The block
// hunts for the sync pair, then checks the eight following bytes against an
// acknowledge frame for the configured class and id, checksum included.
// After the last frame byte one master beat is sent: bit 0 says whether the
// whole frame matched, bits 8:1 and 16:9 hold the class and id bytes seen.
// A byte is registered on entry and checked from there; checking the last
// frame byte loads the result register. One byte is accepted in every
// cycle; the result register lets bytes keep flowing while a result waits,
// and only a second result meeting a stalled master side holds the input.
// The user must write the expected class and id through the configuration
// port while no frame is in flight; the block does not enforce this. Reset
// clears the hunt state, both registers and all valid flags.
// ============================================================================
module ubx_ack_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // ack_match, seen_class,
                                                          // seen_id, zero fill
    input  logic                          i_cfg_we,
    input  logic [ubxa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_wdata
);

    ubxa_pkg::t_cfg    w_cfg;
    ubxa_pkg::t_result w_result;
    logic              w_emit;
    logic              w_go;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    ubxa_pkg::t_result r_out;

    ubxa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ubxa_frame_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign w_go          = r_in_valid && (!w_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.seen_id, r_out.seen_class, r_out.ack_match};

endmodule

>>> src/ubxa_cfg_regs.sv
// ============================================================================
// ubxa_cfg_regs
// Holds the expected class and id written through the configuration port.
// ============================================================================
module ubxa_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ubxa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_wdata,
    output ubxa_pkg::t_cfg                o_cfg
);

    ubxa_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ubxa_pkg::REG_EXP_CLASS: r_cfg.exp_class <= i_cfg_wdata;
                ubxa_pkg::REG_EXP_ID:    r_cfg.exp_id    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/ubxa_frame_match.sv
// ============================================================================
// ubxa_frame_match
// Sync hunt and byte-by-byte comparison against the expected acknowledge
// frame; flags a result on the last frame byte.
// ============================================================================
module ubxa_frame_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [7:0]        i_byte,
    input  ubxa_pkg::t_cfg    i_cfg,
    output logic              o_emit,
    output ubxa_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_SYNC1,
        ST_BODY
    } t_state;

    t_state                             r_state;
    t_state                             n_state;
    logic [ubxa_pkg::BODY_CNT_W-1:0]    r_cnt;
    logic [ubxa_pkg::BODY_CNT_W-1:0]    n_cnt;
    logic                               r_all_eq;
    logic                               n_all_eq;
    logic [7:0]                         r_cls;
    logic [7:0]                         r_id;
    logic                               w_eq;
    logic                               w_last;

    assign w_eq   = (i_byte == ubxa_pkg::expected_byte(r_cnt, i_cfg));
    assign w_last = (r_cnt == ubxa_pkg::POS_CK_B);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_all_eq = r_all_eq;
        unique case (r_state)
            ST_SYNC1: begin
                if (i_byte == ubxa_pkg::SYNC_TWO) begin
                    n_state  = ST_BODY;
                    n_cnt    = '0;
                    n_all_eq = 1'b1;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_BODY: begin
                n_all_eq = r_all_eq & w_eq;
                n_cnt    = r_cnt + 1'b1;
                if (w_last) begin
                    n_state  = ST_HUNT;
                    n_cnt    = '0;
                    n_all_eq = 1'b1;
                end
            end
            default: begin
                n_state = (i_byte == ubxa_pkg::SYNC_ONE) ? ST_SYNC1 : ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_cnt    <= '0;
            r_all_eq <= 1'b1;
            r_cls    <= '0;
            r_id     <= '0;
        end else if (i_go) begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_all_eq <= n_all_eq;
            if (r_state == ST_BODY && r_cnt == ubxa_pkg::POS_CLASS) begin
                r_cls <= i_byte;
            end
            if (r_state == ST_BODY && r_cnt == ubxa_pkg::POS_ID) begin
                r_id <= i_byte;
            end
        end
    end

    assign o_emit               = (r_state == ST_BODY) && w_last;
    assign o_result.ack_match   = r_all_eq & w_eq;
    assign o_result.seen_class  = r_cls;
    assign o_result.seen_id     = r_id;

endmodule
